@@ src/ubdc_pkg.sv @@
// ----------------------------------------------------------------------------
// ubdc_pkg
// shared widths, constants and types for the baud divisor calculator
// ----------------------------------------------------------------------------
package ubdc_pkg;

  localparam int CLK_W      = 28;
  localparam int BAUD_W     = 24;
  localparam int WORD_W     = 16;
  localparam int MANT_W     = 12;
  localparam int FRAC_W     = 4;
  localparam int REM_W      = 7;

  // 25 * clk needs five more bits than the clock field
  localparam int NUM_W      = CLK_W + 5;
  localparam int QUO_W      = NUM_W;
  localparam int SCALED_W   = QUO_W - 1;
  localparam int DIV_STAGES = QUO_W;

  localparam int SCALE_NUM  = 25;
  localparam int HUNDRED    = 100;
  localparam int ROUND_HALF = 50;

  // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP100    = 32'h51EB_851F;
  localparam int          RECIP_SHIFT = 37;
  localparam int          PROD_W      = 64;

  // floor(y / 100) = (y * FRAC_RECIP) >> FRAC_SHIFT for y below 2048
  localparam int          Y_W         = 11;
  localparam logic [10:0] FRAC_RECIP  = 11'd1311;
  localparam int          FRAC_SHIFT  = 17;
  localparam int          FPROD_W     = 22;

  localparam logic [WORD_W-1:0] WORD_ZERO_BAUD = 16'hFFFF;

  // per-item mode bits that ride along the pipeline
  typedef struct packed {
    logic by8;
    logic zero_baud;
  } ubdc_side_t;

endpackage

@@ src/ubdc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// ubdc_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ubdc_div_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ubdc_pkg::NUM_W-1:0]  in_num,
  input  logic [ubdc_pkg::BAUD_W-1:0] in_den,
  input  ubdc_pkg::ubdc_side_t        in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ubdc_pkg::QUO_W-1:0]  out_quo,
  output ubdc_pkg::ubdc_side_t        out_side
);
  import ubdc_pkg::*;

  logic                  v_r    [DIV_STAGES];
  logic [BAUD_W-1:0]     rem_r  [DIV_STAGES];
  logic [NUM_W-1:0]      nq_r   [DIV_STAGES];
  logic [BAUD_W-1:0]     den_r  [DIV_STAGES];
  ubdc_side_t            side_r [DIV_STAGES];

  logic                  src_v    [DIV_STAGES];
  logic [BAUD_W-1:0]     src_rem  [DIV_STAGES];
  logic [NUM_W-1:0]      src_nq   [DIV_STAGES];
  logic [BAUD_W-1:0]     src_den  [DIV_STAGES];
  ubdc_side_t            src_side [DIV_STAGES];

  logic [DIV_STAGES:0]   rdy;

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [BAUD_W:0]   trial;
    logic              ge;
    logic [BAUD_W:0]   diff;
    logic [BAUD_W-1:0] rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    if (i == 0) begin : g_head
      assign src_v[i]    = in_valid;
      assign src_rem[i]  = '0;
      assign src_nq[i]   = in_num;
      assign src_den[i]  = in_den;
      assign src_side[i] = in_side;
    end else begin : g_body
      assign src_v[i]    = v_r[i-1];
      assign src_rem[i]  = rem_r[i-1];
      assign src_nq[i]   = nq_r[i-1];
      assign src_den[i]  = den_r[i-1];
      assign src_side[i] = side_r[i-1];
    end

    assign rdy[i] = ~v_r[i] | rdy[i+1];

    // bring down the next numerator bit, subtract when it fits
    always_comb begin
      trial   = {src_rem[i], src_nq[i][NUM_W-1]};
      diff    = trial - {1'b0, src_den[i]};
      ge      = (trial >= {1'b0, src_den[i]});
      rem_nxt = ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
      nq_nxt  = {src_nq[i][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v[i];
      end
      if (rdy[i]) begin
        rem_r[i]  <= rem_nxt;
        nq_r[i]   <= nq_nxt;
        den_r[i]  <= src_den[i];
        side_r[i] <= src_side[i];
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quo   = nq_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

@@ src/uart_baud_divisor_calc_core.sv @@
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core
// fractional baud-rate divisor word from bus clock, baud rate and mode
// ----------------------------------------------------------------------------
//
// channel  direction  tdata                                   tuser
// -------  ---------  --------------------------------------  -------------------------
// in_      slave      [27:0] slow clk, [55:28] fast clk,      [0] on_fast_bus,
//                     [79:56] baud_rate                       [1] oversample_by_8
// out_     master     [15:0] divisor_word                     -
//
// one transaction accepted per cycle unless a stalled output backs up the pipeline;
// stages: one input stage, 33 divider stages (one quotient bit each), the
// divide-by-100 multiply stage, the remainder stage and the output register
// every stage has its own valid bit and a ready that chains combinationally
// through every later stage, so a stalled output keeps filling empty stages and
// nothing is lost or repeated
// rst_n (synchronous, active low) clears the valid bits only
//
module uart_baud_divisor_calc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // slave side: [27:0] slow_bus_clock_hz, [55:28] fast_bus_clock_hz,
  // [79:56] baud_rate
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [79:0]                  in_tdata,
  // [0] on_fast_bus, [1] oversample_by_8
  input  logic [1:0]                   in_tuser,
  // master side: [15:0] divisor_word
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ubdc_pkg::WORD_W-1:0]  out_tdata
);
  import ubdc_pkg::*;

  // input field unpacking
  logic [CLK_W-1:0]  slow_clk;
  logic [CLK_W-1:0]  fast_clk;
  logic [BAUD_W-1:0] baud;
  logic              on_fast;
  logic              by8;

  assign slow_clk = in_tdata[CLK_W-1:0];
  assign fast_clk = in_tdata[2*CLK_W-1:CLK_W];
  assign baud     = in_tdata[2*CLK_W+BAUD_W-1:2*CLK_W];
  assign on_fast  = in_tuser[0];
  assign by8      = in_tuser[1];

  // stage 0: select clock and scale by 25
  logic              s0_v_r;
  logic [NUM_W-1:0]  s0_num_r;
  logic [BAUD_W-1:0] s0_den_r;
  ubdc_side_t        s0_side_r;
  logic [CLK_W-1:0]  clk_sel;
  logic [NUM_W-1:0]  num_nxt;
  ubdc_side_t        side_nxt;
  logic              div_in_ready;

  assign clk_sel   = on_fast ? fast_clk : slow_clk;
  assign num_nxt   = NUM_W'(clk_sel) * NUM_W'(SCALE_NUM);
  assign side_nxt  = '{by8: by8, zero_baud: (baud == '0)};
  assign in_tready = ~s0_v_r | div_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_tready) begin
      s0_v_r <= in_tvalid;
    end
    if (in_tready) begin
      s0_num_r  <= num_nxt;
      s0_den_r  <= baud;
      s0_side_r <= side_nxt;
    end
  end

  // 25*clk / baud; the extra /2 or /4 is a shift of the quotient
  logic             div_v;
  logic [QUO_W-1:0] div_quo;
  ubdc_side_t       div_side;
  logic             m_rdy;

  ubdc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_ready  (div_in_ready),
    .in_num    (s0_num_r),
    .in_den    (s0_den_r),
    .in_side   (s0_side_r),
    .out_valid (div_v),
    .out_ready (m_rdy),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // mantissa stage: scaled / 100 by reciprocal multiply
  logic                m_v_r;
  logic [MANT_W-1:0]   m_mant_r;
  logic [REM_W-1:0]    m_low_r;
  ubdc_side_t          m_side_r;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   m_prod;
  logic                r_rdy;

  assign scaled = div_side.by8 ? div_quo[QUO_W-1:1] : {1'b0, div_quo[QUO_W-1:2]};
  assign m_prod = PROD_W'(scaled) * PROD_W'(RECIP100);
  assign m_rdy  = ~m_v_r | r_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_rdy) begin
      m_v_r <= div_v;
    end
    if (m_rdy) begin
      // only the low 12 mantissa bits survive the 16-bit word
      m_mant_r <= m_prod[RECIP_SHIFT +: MANT_W];
      // the remainder is below 100, so it only needs the low bits
      m_low_r  <= scaled[REM_W-1:0];
      m_side_r <= div_side;
    end
  end

  // remainder stage: scaled - 100 * mantissa, taken mod 128
  logic               r_v_r;
  logic [MANT_W-1:0]  r_mant_r;
  logic [REM_W-1:0]   r_rem_r;
  ubdc_side_t         r_side_r;
  logic [REM_W-1:0]   mant_x100;
  logic [REM_W-1:0]   rem_nxt;
  logic               o_rdy;

  assign mant_x100 = REM_W'(m_mant_r[REM_W-1:0] * REM_W'(HUNDRED));
  assign rem_nxt   = m_low_r - mant_x100;
  assign r_rdy     = ~r_v_r | o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_rdy) begin
      r_v_r <= m_v_r;
    end
    if (r_rdy) begin
      r_mant_r <= m_mant_r;
      r_rem_r  <= rem_nxt;
      r_side_r <= m_side_r;
    end
  end

  // output stage: rounded fraction and word assembly
  logic                 out_tvalid_r;
  logic [WORD_W-1:0]    out_tdata_r;
  logic [Y_W-1:0]       frac_y;
  logic [FPROD_W-1:0]   frac_prod;
  logic [FRAC_W-1:0]    frac_raw;
  logic [FRAC_W-1:0]    frac;
  logic [WORD_W-1:0]    word_nxt;

  always_comb begin
    // rem * 8 or rem * 16, plus one half for rounding
    frac_y    = (r_side_r.by8 ? {1'b0, r_rem_r, 3'b000} : {r_rem_r, 4'b0000})
                + Y_W'(ROUND_HALF);
    frac_prod = FPROD_W'(frac_y) * FPROD_W'(FRAC_RECIP);
    frac_raw  = frac_prod[FRAC_SHIFT +: FRAC_W];
    // carry out of the fraction is dropped by the mask
    frac      = r_side_r.by8 ? {1'b0, frac_raw[2:0]} : frac_raw;
    word_nxt  = r_side_r.zero_baud ? WORD_ZERO_BAUD : {r_mant_r, frac};
  end

  assign o_rdy = ~out_tvalid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (o_rdy) begin
      out_tvalid_r <= r_v_r;
    end
    if (o_rdy) begin
      out_tdata_r <= word_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
